// ===== hdl/pisp_pkg.sv =====
`default_nettype none
package pisp_pkg;

  localparam int unsigned TABLE_DEPTH_DEF  = 64;
  localparam int unsigned MAX_PREFETCH_DEF = 8;

  // Configuration register indexes
  localparam logic [1:0] REG_LINE_OFFSET   = 2'd0;
  localparam logic [1:0] REG_PREFETCH_CNT  = 2'd1;
  localparam logic [1:0] REG_CONF_THRESH   = 2'd2;

  localparam logic [3:0] LINE_OFFSET_RST   = 4'd6;
  localparam logic [3:0] PREFETCH_CNT_RST  = 4'd4;
  localparam logic [7:0] CONF_THRESH_RST   = 8'd2;

  localparam logic [7:0] CONF_MAX          = 8'hFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_CALC,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [63:0] last_line;
    logic [63:0] stride;
    logic [7:0]  conf;
  } entry_t;

endpackage
`default_nettype wire

// ===== hdl/pc_indexed_stride_prefetcher.sv =====
`default_nettype none
// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tdata: access_addr, pc; tuser: pc_present
// m_axis    out  m_axis_tvalid/tready    tdata: pf_line; tlast: last_of_run
// cfg       in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Sequence: an access steps through accept, table read, stride subtract,
// compare and write-back, then emits any prefetch addresses in turn; the
// single-port read-modify-write of the prediction table sets this order. A
// depth that is not a power of two adds a byte-serial index reduction first.
// Reset: a clearing pass zeroes every table entry before the
// first access is accepted; configuration writes are taken throughout.
// Stalls: a held result stalls emission only; the next access is accepted
// once the last address of a run sits in the output register.
module pc_indexed_stride_prefetcher
  import pisp_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int unsigned MAX_PREFETCH = MAX_PREFETCH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [127:0]  s_axis_tdata,   // [63:0] access_addr, [127:64] pc
  input  wire logic [0:0]    s_axis_tuser,   // [0] pc_present
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [63:0]        m_axis_tdata,   // [63:0] pf_line
  output logic               m_axis_tlast,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [7:0]    cfg_data_i
);

  localparam int unsigned IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam bit          IS_POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);

  state_e state_q, state_d;

  logic [3:0] line_off_q;
  logic [3:0] pf_cnt_q;
  logic [7:0] conf_thr_q;

  logic [63:0] line_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] clr_q;
  logic [63:0] diff_q;
  logic [63:0] acc_q;
  logic [63:0] step_q;
  logic [3:0]  left_q;
  logic        out_valid_q;
  logic [63:0] out_data_q;
  logic        out_last_q;

  logic        in_xfer;
  logic        out_load;
  logic        mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t      mem_wdata;
  entry_t      rdata_q;
  entry_t      mem [TABLE_DEPTH];

  logic        mod_done;
  logic [IDX_W-1:0] mod_rem;

  logic        clr_done;
  logic        stride_match;
  logic [7:0]  conf_inc;
  logic [3:0]  pf_n;
  logic        do_emit;
  logic [63:0] line_mask;

  assign in_xfer     = s_axis_tvalid && s_axis_tready;
  assign out_load    = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);
  assign clr_done    = (clr_q == IDX_W'(TABLE_DEPTH - 1));
  assign cfg_ready_o = 1'b1;
  assign line_mask   = ~((64'd1 << line_off_q) - 64'd1);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // Table index: plain bit slice for a power-of-two depth, else reduce
  // pc >> 2 modulo the depth one byte per cycle, most significant first.
  if (IS_POW2) begin : g_pow2
    assign mod_done = 1'b1;
    if (TABLE_DEPTH > 1) begin : g_slice
      assign mod_rem = s_axis_tuser[0] ? s_axis_tdata[66 +: IDX_W] : '0;
    end else begin : g_single
      assign mod_rem = '0;
    end
  end else begin : g_mod
    localparam logic [IDX_W+7:0] DEPTH_V = (IDX_W + 8)'(TABLE_DEPTH);
    logic [63:0]      pcw_q;
    logic [2:0]       cnt_q;
    logic [IDX_W-1:0] rem_q;
    logic [IDX_W+7:0] t;

    always_comb begin
      t = {rem_q, pcw_q[63:56]};
      for (int j = 7; j >= 0; j--) begin
        if (t >= (DEPTH_V << j)) begin
          t = t - (DEPTH_V << j);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q <= '0;
      end else if (in_xfer) begin
        cnt_q <= '0;
      end else if (state_q == ST_MOD) begin
        cnt_q <= cnt_q + 3'd1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (in_xfer) begin
        pcw_q <= s_axis_tuser[0] ? {2'b00, s_axis_tdata[127:66]} : 64'd0;
        rem_q <= '0;
      end else if (state_q == ST_MOD) begin
        pcw_q <= {pcw_q[55:0], 8'd0};
        rem_q <= t[IDX_W-1:0];
      end
    end

    assign mod_done = (cnt_q == 3'd7);
    assign mod_rem  = t[IDX_W-1:0];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_off_q <= LINE_OFFSET_RST;
      pf_cnt_q   <= PREFETCH_CNT_RST;
      conf_thr_q <= CONF_THRESH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_LINE_OFFSET:  line_off_q <= cfg_data_i[3:0];
        REG_PREFETCH_CNT: pf_cnt_q   <= cfg_data_i[3:0];
        REG_CONF_THRESH:  conf_thr_q <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Entry update
  always_comb begin
    stride_match = (diff_q != 64'd0) && (diff_q == rdata_q.stride);
    conf_inc     = (rdata_q.conf == CONF_MAX) ? CONF_MAX : rdata_q.conf + 8'd1;
    if (32'(pf_cnt_q) > MAX_PREFETCH) begin
      pf_n = 4'(MAX_PREFETCH);
    end else begin
      pf_n = pf_cnt_q;
    end
    do_emit = rdata_q.valid && stride_match && (conf_inc >= conf_thr_q) && (pf_n != 4'd0);

    mem_wdata.valid     = 1'b1;
    mem_wdata.last_line = line_q;
    mem_wdata.stride    = rdata_q.stride;
    mem_wdata.conf      = 8'd0;
    if (rdata_q.valid) begin
      if (stride_match) begin
        mem_wdata.conf = conf_inc;
      end else begin
        mem_wdata.stride = diff_q;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_done) state_d = ST_IDLE;
      ST_IDLE:   if (in_xfer) state_d = IS_POW2 ? ST_READ : ST_MOD;
      ST_MOD:    if (mod_done) state_d = ST_READ;
      ST_READ:   state_d = ST_CALC;
      ST_CALC:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = do_emit ? ST_EMIT : ST_IDLE;
      ST_EMIT:   if (out_load && left_q == 4'd1) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    mem_we        = (state_q == ST_CLEAR) || (state_q == ST_UPDATE);
    mem_waddr     = (state_q == ST_CLEAR) ? clr_q : idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (state_q == ST_UPDATE) begin
        left_q <= pf_n;
      end else if (out_load) begin
        left_q <= left_q - 4'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      line_q <= s_axis_tdata[63:0] & line_mask;
    end
    if ((in_xfer && IS_POW2) || (state_q == ST_MOD && mod_done)) begin
      idx_q <= mod_rem;
    end
    if (state_q == ST_CALC) begin
      diff_q <= line_q - rdata_q.last_line;
    end
    if (state_q == ST_UPDATE) begin
      acc_q  <= line_q;
      step_q <= diff_q;
    end else if (out_load) begin
      acc_q <= acc_q + step_q;
    end
    if (out_load) begin
      out_data_q <= acc_q + step_q;
      out_last_q <= (left_q == 4'd1);
    end
  end

  // Prediction table, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= (state_q == ST_CLEAR) ? entry_t'('0) : mem_wdata;
    end
    if (state_q == ST_READ) begin
      rdata_q <= mem[idx_q];
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != ST_IDLE)
    else $error("access transfer did not start the table sequence");

  a_emit_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> left_q != 4'd0)
    else $error("emission running with no addresses left");

  a_zero_stride_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && rdata_q.stride == 64'd0) |=> state_q != ST_EMIT)
    else $error("prefetch run started on a zero stride");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && left_q == 4'd1) |=> (state_q == ST_IDLE && m_axis_tlast))
    else $error("final prefetch address did not close the run");

endmodule
`default_nettype wire
